// ----- design/sort_records_by_score_descending_assert.svh -----
// Assertion macros used by the checker file of the record sorter
`ifndef SORT_RECORDS_BY_SCORE_DESCENDING_ASSERT_SVH
`define SORT_RECORDS_BY_SCORE_DESCENDING_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define SRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/srt_pkg.sv -----
// Package of the record sorter: payload types, control types and constants
`default_nettype none

package srt_pkg;

  localparam int unsigned MAX_RECORDS = 32;

  typedef struct packed {
    logic signed [31:0] score_in;
    logic [63:0]        name_word0_in;
    logic [63:0]        name_word1_in;
    logic [63:0]        name_word2_in;
    logic               final_record;
  } srt_in_t;

  typedef struct packed {
    logic signed [31:0] score_out;
    logic [63:0]        name_word0_out;
    logic [63:0]        name_word1_out;
    logic [63:0]        name_word2_out;
    logic               end_of_list;
    logic               overflowed;
  } srt_out_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [63:0]        name0;
    logic [63:0]        name1;
    logic [63:0]        name2;
  } srt_rec_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH_P,
    ST_LOAD_P,
    ST_FETCH_Q,
    ST_CMP,
    ST_EMIT
  } srt_state_e;

  typedef struct packed {
    logic store;
    logic drop;
    logic start;
    logic rd_p;
    logic load_cur;
    logic rd_q;
    logic cmp;
    logic emit;
    logic clear;
  } srt_cmd_t;

  typedef struct packed {
    logic full;
    logic p_last;
    logic q_last;
  } srt_sts_t;

endpackage

`default_nettype wire

// ----- design/srt_if.sv -----
// Valid/ready channel interfaces for input and result words
`default_nettype none

interface srt_in_if;
  import srt_pkg::*;
  logic    valid;
  logic    ready;
  srt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srt_out_if;
  import srt_pkg::*;
  logic     valid;
  logic     ready;
  srt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/srt_ctrl.sv -----
// Controller state machine of the record sorter
`default_nettype none

module srt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_final_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire srt_pkg::srt_sts_t sts_i,
  output srt_pkg::srt_cmd_t      cmd_o
);
  import srt_pkg::*;

  srt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store = !sts_i.full;
          cmd_o.drop  = sts_i.full;
          if (in_final_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_FETCH_P;
          end
        end
      end
      ST_FETCH_P: begin
        cmd_o.rd_p = 1'b1;
        state_d    = ST_LOAD_P;
      end
      ST_LOAD_P: begin
        cmd_o.load_cur = 1'b1;
        state_d        = sts_i.p_last ? ST_EMIT : ST_FETCH_Q;
      end
      ST_FETCH_Q: begin
        cmd_o.rd_q = 1'b1;
        state_d    = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.q_last ? ST_EMIT : ST_FETCH_Q;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (sts_i.p_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_FETCH_P;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- design/srt_dp.sv -----
// Datapath of the record sorter: record memory, counters, compare and output word
`default_nettype none

module srt_dp #(
  parameter int unsigned MaxRecords = srt_pkg::MAX_RECORDS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire srt_pkg::srt_in_t  in_data_i,
  input  wire srt_pkg::srt_cmd_t cmd_i,
  output srt_pkg::srt_sts_t      sts_o,
  output srt_pkg::srt_out_t      out_data_o
);
  import srt_pkg::*;

  localparam int unsigned IW = $clog2(MaxRecords);
  localparam int unsigned CW = $clog2(MaxRecords + 1);

  srt_rec_t        mem_q [MaxRecords];
  srt_rec_t        rd_q;
  srt_rec_t        cur_q;
  srt_rec_t        in_rec;
  srt_rec_t        wr_data;
  srt_out_t        out_q;
  logic [CW-1:0]   count_q;
  logic [IW-1:0]   p_q;
  logic [IW-1:0]   q_q;
  logic            ovf_q;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic            wr_en;
  logic            gt;

  assign in_rec.score = in_data_i.score_in;
  assign in_rec.name0 = in_data_i.name_word0_in;
  assign in_rec.name1 = in_data_i.name_word1_in;
  assign in_rec.name2 = in_data_i.name_word2_in;

  assign gt      = rd_q.score > cur_q.score;
  assign rd_addr = cmd_i.rd_p ? p_q : q_q;
  assign wr_addr = cmd_i.store ? count_q[IW-1:0] : q_q;
  assign wr_data = cmd_i.store ? in_rec : cur_q;
  assign wr_en   = cmd_i.store || (cmd_i.cmp && gt);

  assign sts_o.full   = count_q == CW'(MaxRecords);
  assign sts_o.p_last = CW'(p_q) == count_q - CW'(1);
  assign sts_o.q_last = CW'(q_q) == count_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_p || cmd_i.rd_q) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      p_q     <= '0;
      q_q     <= '0;
    end else begin
      if (cmd_i.store) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.drop) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.start) begin
        p_q <= '0;
      end else if (cmd_i.emit) begin
        p_q <= p_q + IW'(1);
      end
      if (cmd_i.load_cur) begin
        q_q <= p_q + IW'(1);
      end else if (cmd_i.cmp) begin
        q_q <= q_q + IW'(1);
      end
    end
  end

  // hold the running maximum for position p; swap it out on a strictly greater score
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur || (cmd_i.cmp && gt)) begin
      cur_q <= rd_q;
    end
    if (cmd_i.emit) begin
      out_q.score_out      <= cur_q.score;
      out_q.name_word0_out <= cur_q.name0;
      out_q.name_word1_out <= cur_q.name1;
      out_q.name_word2_out <= cur_q.name2;
      out_q.end_of_list    <= sts_o.p_last;
      out_q.overflowed     <= ovf_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ----- design/sort_records_by_score_descending.sv -----
// Top level of the record sorter: exchange sort, highest score first
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    one record: score, three name words, final flag
//   out_o    out  valid/ready    one sorted record: end_of_list, overflowed
//
// Loading accepts one record per cycle; records past MaxRecords are dropped.
// After the final record, each position p is fetched and loaded, each later
// record is fetched from the record memory and compared against it, and the
// running maximum for p is emitted; output stalls hold the emit.
// Input is not ready from the final record until the last word is emitted.
// Reset clears the counters and state; the record memory is not cleared.
`default_nettype none

module sort_records_by_score_descending #(
  parameter int unsigned MaxRecords = srt_pkg::MAX_RECORDS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srt_in_if.sink     in_i,
  srt_out_if.source  out_o
);
  import srt_pkg::*;

  srt_cmd_t cmd;
  srt_sts_t sts;

  srt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_final_i  (in_i.data.final_record),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srt_dp #(
    .MaxRecords (MaxRecords)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

endmodule

`default_nettype wire

// ----- design/srt_chk.sv -----
// Port-level checker of the record sorter and its bind to the top level
`default_nettype none

`include "sort_records_by_score_descending_assert.svh"

module srt_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              in_final_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire srt_pkg::srt_out_t out_data_i
);
  import srt_pkg::*;

  `SRT_ASSERT_NEXT(a_out_valid_hold, out_valid_i && !out_ready_i, out_valid_i, "out valid dropped")
  `SRT_ASSERT_NEXT(a_out_data_hold, out_valid_i && !out_ready_i, $stable(out_data_i), "out word moved")
  `SRT_ASSERT_NEXT(a_final_closes, in_valid_i && in_ready_i && in_final_i, !in_ready_i, "input open after final")
  `SRT_ASSERT_IMPL(a_no_load_mid_list, out_valid_i && !out_data_i.end_of_list, !in_ready_i, "input open mid list")

endmodule

bind sort_records_by_score_descending srt_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_final_i  (in_i.data.final_record),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

// ----- verif/sort_records_by_score_descending_tb.sv -----
// Testbench of the record sorter: directed and random record sets, predicted exchange sort, word-by-word check
module sort_records_by_score_descending_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SCORE_MAX = 32'sh7fff_ffff;

  logic clk_i;
  logic rst_ni;

  srt_in_if  in_if ();
  srt_out_if out_if ();

  sort_records_by_score_descending dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  srt_in_t  pending_words[$];
  srt_rec_t kept_records[$];
  srt_out_t sorted_words[$];
  logic     set_overflow;
  int       errors;
  int       burst_left;
  int       gap_left;
  int       idle_cycles;
  int       stall_mode;
  int       mode_cycles;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic queue_record(input logic signed [31:0] score, input logic [63:0] n0,
                              input logic [63:0] n1, input logic [63:0] n2, input logic fin);
    srt_in_t w;
    w.score_in = score;
    w.name_word0_in = n0;
    w.name_word1_in = n1;
    w.name_word2_in = n2;
    w.final_record = fin;
    pending_words.push_back(w);
  endtask

  function automatic logic [63:0] random_name_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  // store or drop one accepted record; on the final one, sort and queue the set
  task automatic take_record(input srt_in_t w);
    srt_rec_t r;
    srt_rec_t t;
    srt_out_t o;
    int n;
    if (kept_records.size() < MAX_RECORDS) begin
      r.score = w.score_in;
      r.name0 = w.name_word0_in;
      r.name1 = w.name_word1_in;
      r.name2 = w.name_word2_in;
      kept_records.push_back(r);
    end else begin
      set_overflow = 1'b1;
    end
    if (w.final_record) begin
      n = kept_records.size();
      for (int p = 0; p + 1 < n; p++) begin
        for (int q = p + 1; q < n; q++) begin
          if (kept_records[q].score > kept_records[p].score) begin
            t = kept_records[p];
            kept_records[p] = kept_records[q];
            kept_records[q] = t;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        o.score_out = kept_records[k].score;
        o.name_word0_out = kept_records[k].name0;
        o.name_word1_out = kept_records[k].name1;
        o.name_word2_out = kept_records[k].name2;
        o.end_of_list = (k == n - 1);
        o.overflowed = set_overflow;
        sorted_words.push_back(o);
      end
      kept_records.delete();
      set_overflow = 1'b0;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_words.size() > 0) begin
        in_if.data <= pending_words.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that switches at random among four modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode = 0;
      mode_cycles = 0;
    end else begin
      mode_cycles++;
      if (mode_cycles % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= $urandom_range(0, 1);
        default: out_if.ready <= ((mode_cycles % 7) < 2);
      endcase
    end
  end

  // predict on accepted records, check accepted result words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) take_record(in_if.data);
      if (out_if.valid && out_if.ready) begin
        if (sorted_words.size() == 0) begin
          report_mismatch("word with nothing expected", {32'b0, out_if.data.score_out}, '0);
        end else begin
          srt_out_t want;
          srt_out_t got;
          want = sorted_words.pop_front();
          got = out_if.data;
          if (got.score_out !== want.score_out)
            report_mismatch("score_out", {32'b0, got.score_out}, {32'b0, want.score_out});
          if (got.name_word0_out !== want.name_word0_out)
            report_mismatch("name_word0_out", got.name_word0_out, want.name_word0_out);
          if (got.name_word1_out !== want.name_word1_out)
            report_mismatch("name_word1_out", got.name_word1_out, want.name_word1_out);
          if (got.name_word2_out !== want.name_word2_out)
            report_mismatch("name_word2_out", got.name_word2_out, want.name_word2_out);
          if (got.end_of_list !== want.end_of_list)
            report_mismatch("end_of_list", 64'(got.end_of_list), 64'(want.end_of_list));
          if (got.overflowed !== want.overflowed)
            report_mismatch("overflowed", 64'(got.overflowed), 64'(want.overflowed));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("sort_records_by_score_descending regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int set_len;
    int pick;
    bit tie_set;
    logic signed [31:0] score;

    errors = 0;
    set_overflow = 1'b0;
    idle_cycles = 0;

    queue_record(SCORE_MIN, '1, '1, '1, 1'b1);
    queue_record(SCORE_MAX, '0, '0, '0, 1'b1);

    queue_record(32'sd0, 64'h1, 64'h11, 64'h111, 1'b0);
    queue_record(SCORE_MAX, 64'h2, 64'h22, 64'h222, 1'b0);
    queue_record(SCORE_MIN, 64'h3, 64'h33, 64'h333, 1'b0);
    queue_record(-32'sd1, 64'h4, 64'h44, 64'h444, 1'b0);
    queue_record(32'sd1, 64'h5, 64'h55, 64'h555, 1'b0);
    queue_record(SCORE_MAX, 64'h6, 64'h66, 64'h666, 1'b1);

    for (int k = 0; k < 5; k++)
      queue_record(32'sd5, 64'(k), {$urandom, $urandom}, {$urandom, $urandom}, k == 4);

    for (int k = 0; k < 4; k++)
      queue_record(32'(k - 2), 64'hA0 + 64'(k), '1, '0, k == 3);

    for (int k = 0; k < 3; k++)
      queue_record(32'(30 - k), 64'hB0 + 64'(k), '0, '1, k == 2);

    while (pending_words.size() < RANDOM_ITEMS + 20) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) set_len = $urandom_range(1, 6);
      else if (pick < 8) set_len = $urandom_range(7, 20);
      else if (pick == 8) set_len = $urandom_range(MAX_RECORDS - 1, MAX_RECORDS);
      else set_len = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
      tie_set = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < set_len; k++) begin
        if (tie_set) begin
          score = int'($urandom_range(0, 3)) - 1;
        end else begin
          case ($urandom_range(0, 5))
            0: score = SCORE_MIN;
            1: score = SCORE_MAX;
            2: score = int'($urandom_range(0, 8)) - 4;
            default: score = $urandom;
          endcase
        end
        queue_record(score, random_name_word(), random_name_word(), random_name_word(),
                     k == set_len - 1);
      end
    end

    @(posedge clk_i);
    while (!rst_ni || pending_words.size() > 0 || in_if.valid) @(posedge clk_i);
    while (sorted_words.size() > 0 || kept_records.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("sort_records_by_score_descending regression: pass");
    end else begin
      $display("sort_records_by_score_descending regression: fail");
    end
    $finish;
  end

endmodule

// ----- sort_records_by_score_descending.f -----
+incdir+design
design/srt_pkg.sv
design/srt_if.sv
design/srt_ctrl.sv
design/srt_dp.sv
design/sort_records_by_score_descending.sv
design/srt_chk.sv
verif/sort_records_by_score_descending_tb.sv
